[src/afr_pkg.sv]
// afr_pkg: shared types and constants of the API frame receiver
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  // largest frame in bytes, start byte and checksum included
  localparam int MAX_FRAME_DEF = 256;

  // framing bytes
  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  // configuration register indexes and reset values
  localparam logic CFG_IDX_IDLE_GAP   = 1'b0;
  localparam logic CFG_IDX_MAX_LENGTH = 1'b1;

  localparam logic [15:0] IDLE_GAP_RST   = 16'd50;
  localparam logic [7:0]  MAX_LENGTH_RST = 8'd252;

  // parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_OK    = 3'd1,
    EV_START = 3'd2,
    EV_LONG  = 3'd3,
    EV_SUM   = 3'd4,
    EV_CUT   = 3'd5
  } event_t;

  // input item modes
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // configuration as seen by the parser
  typedef struct packed {
    logic [15:0] idle_gap;
    logic [7:0]  max_length;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  frame_type;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
  } result_t;

  // result queue status
  typedef struct packed {
    logic head_valid;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

[src/afr_in_if.sv]
// afr_in_if: input channel of the frame receiver (bytes and ticks)
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface afr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_in;

  modport source (output valid, output mode, output byte_in, input ready);
  modport sink   (input valid, input mode, input byte_in, output ready);
endinterface

`default_nettype wire

[src/afr_out_if.sv]
// afr_out_if: result channel of the frame receiver
// valid/ready handshake; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface afr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] frame_type;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_length;

  modport source (output valid, output event_res, output frame_type, output data_byte,
                  output byte_index, output frame_length, input ready);
  modport sink   (input valid, input event_res, input frame_type, input data_byte,
                  input byte_index, input frame_length, output ready);
endinterface

`default_nettype wire

[src/afr_cfg_if.sv]
// afr_cfg_if: configuration write channel of the frame receiver
// valid/ready handshake carrying register index and write data
`timescale 1ns / 1ps
`default_nettype none

interface afr_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/afr_parser.sv]
// afr_parser: frame parsing state machine, one byte or tick per cycle while accept is high
// depends on afr_pkg
`timescale 1ns / 1ps
`default_nettype none

module afr_parser #(
  parameter int MAX_FRAME = afr_pkg::MAX_FRAME_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             mode,
  input  wire logic [7:0]       byte_in,
  input  wire afr_pkg::cfg_t    cfg,
  output afr_pkg::result_t      res,
  output logic                  res_valid
);

  localparam logic [15:0] LEN_CAP = 16'(MAX_FRAME - 4);

  afr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] gap_r, gap_nxt;

  logic [7:0]  len_sat;
  logic [15:0] limit;
  logic [15:0] len_full;
  logic [7:0]  sum_add;
  logic [7:0]  left_dec;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= afr_pkg::PH_HUNT;
      length_r <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      sum_r    <= '0;
      type_r   <= '0;
      gap_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      type_r   <= type_nxt;
      gap_r    <= gap_nxt;
    end
  end

  // shared datapath pieces
  assign len_sat  = (|length_r[15:8]) ? 8'hFF : length_r[7:0];
  assign limit    = ({8'd0, cfg.max_length} > LEN_CAP) ? LEN_CAP : {8'd0, cfg.max_length};
  assign len_full = {length_r[15:8], byte_in};
  assign sum_add  = sum_r + byte_in;
  assign left_dec = left_r - 8'd1;

  // next state and result
  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    gap_nxt    = gap_r;
    res_valid  = 1'b0;
    res        = '{event_res: afr_pkg::EV_DATA, frame_type: type_r, data_byte: 8'd0,
                   byte_index: pos_r, frame_length: len_sat};

    if (accept) begin
      if (mode == afr_pkg::MODE_TICK) begin
        // idle tick: count the gap, leave the frame once it is long enough
        gap_nxt = (gap_r == 16'hFFFF) ? gap_r : gap_r + 16'd1;
        if (phase_r != afr_pkg::PH_HUNT && gap_nxt > cfg.idle_gap) begin
          phase_nxt = afr_pkg::PH_HUNT;
          if (phase_r != afr_pkg::PH_DISCARD) begin
            res_valid     = 1'b1;
            res.event_res = afr_pkg::EV_CUT;
          end
        end
      end else begin
        gap_nxt = '0;
        unique case (phase_r)
          afr_pkg::PH_HUNT: begin
            if (byte_in == afr_pkg::START_BYTE) begin
              length_nxt = '0;
              left_nxt   = '0;
              pos_nxt    = '0;
              sum_nxt    = '0;
              type_nxt   = '0;
              phase_nxt  = afr_pkg::PH_LEN_HI;
            end else begin
              phase_nxt = afr_pkg::PH_DISCARD;
              res_valid = 1'b1;
              res       = '{event_res: afr_pkg::EV_START, frame_type: 8'd0,
                            data_byte: 8'd0, byte_index: 8'd0, frame_length: 8'd0};
            end
          end
          afr_pkg::PH_LEN_HI: begin
            length_nxt = {byte_in, 8'd0};
            phase_nxt  = afr_pkg::PH_LEN_LO;
          end
          afr_pkg::PH_LEN_LO: begin
            length_nxt = len_full;
            if (len_full == 16'd0 || len_full > limit) begin
              phase_nxt = afr_pkg::PH_DISCARD;
              res_valid = 1'b1;
              res       = '{event_res: afr_pkg::EV_LONG, frame_type: 8'd0,
                            data_byte: 8'd0, byte_index: 8'd0,
                            frame_length: (|len_full[15:8]) ? 8'hFF : len_full[7:0]};
            end else begin
              phase_nxt = afr_pkg::PH_TYPE;
            end
          end
          afr_pkg::PH_TYPE: begin
            type_nxt  = byte_in;
            sum_nxt   = byte_in;
            pos_nxt   = '0;
            left_nxt  = length_r[7:0] - 8'd1;
            phase_nxt = (left_nxt == 8'd0) ? afr_pkg::PH_CHECK : afr_pkg::PH_PAYLOAD;
          end
          afr_pkg::PH_PAYLOAD: begin
            res_valid     = 1'b1;
            res.data_byte = byte_in;
            sum_nxt       = sum_add;
            pos_nxt       = pos_r + 8'd1;
            left_nxt      = left_dec;
            if (left_dec == 8'd0) begin
              phase_nxt = afr_pkg::PH_CHECK;
            end
          end
          afr_pkg::PH_CHECK: begin
            sum_nxt   = sum_add;
            res_valid = 1'b1;
            if (sum_add == afr_pkg::SUM_GOOD) begin
              phase_nxt     = afr_pkg::PH_HUNT;
              res.event_res = afr_pkg::EV_OK;
            end else begin
              phase_nxt     = afr_pkg::PH_DISCARD;
              res.event_res = afr_pkg::EV_SUM;
            end
          end
          default: begin
            // discarding, and codes with no meaning
            phase_nxt = afr_pkg::PH_DISCARD;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[src/afr_out_queue.sv]
// afr_out_queue: two-entry result buffer (output register plus skid entry)
// depends on afr_pkg
`timescale 1ns / 1ps
`default_nettype none

module afr_out_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire afr_pkg::result_t   push_data,
  input  wire logic               pop_ready,
  output afr_pkg::result_t        head,
  output afr_pkg::queue_stat_t    stat
);

  afr_pkg::result_t head_r, skid_r;
  logic head_valid_r, skid_valid_r;
  logic pop;

  assign pop             = head_valid_r & pop_ready;
  assign head            = head_r;
  assign stat.head_valid = head_valid_r;
  assign stat.full       = skid_valid_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      head_valid_r <= skid_valid_r | push;
      skid_valid_r <= skid_valid_r & push;
    end else if (push) begin
      head_valid_r <= 1'b1;
      skid_valid_r <= head_valid_r;
    end
  end

  // payload entries
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= push_data;
        end
      end else if (push) begin
        head_r <= push_data;
      end
    end else if (push) begin
      if (head_valid_r) begin
        skid_r <= push_data;
      end else begin
        head_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

[src/api_frame_receiver.sv]
// api_frame_receiver: top level of the API frame receiver
// depends on afr_pkg, afr_in_if, afr_out_if, afr_cfg_if, afr_parser, afr_out_queue
//
// Usage:
//   in_chan carries one item per transaction: a received UART byte (mode 0)
//   or a one millisecond tick (mode 1). Frames are 0x7E, 16-bit big-endian
//   length, type byte, payload, checksum. out_chan carries zero or one result
//   per input item: a payload byte, frame ok, bad start, bad length, checksum
//   error or cut short. cfg_chan writes idle_gap (index 0) and max_length
//   (index 1); it is always ready and should be used only while idle.
//   A result is registered in the result buffer before it appears on
//   out_chan. Throughput: one input item per cycle while in_chan ready is
//   high, from the parser state machine feeding a two-entry result buffer.
//   Stall: when out_chan stalls, results collect in the buffer; in_chan
//   ready drops only while both entries hold results, and rises again on
//   the next cycle after a result is taken.
//   Reset: rst_n (synchronous, active low) empties the buffer, puts the
//   parser into hunting for a start byte and loads idle_gap = 50 and
//   max_length = 252.
`timescale 1ns / 1ps
`default_nettype none

module api_frame_receiver #(
  parameter int MAX_FRAME = afr_pkg::MAX_FRAME_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  afr_in_if.sink     in_chan,
  afr_out_if.source  out_chan,
  afr_cfg_if.sink    cfg_chan
);

  logic [15:0] idle_gap_r;
  logic [7:0]  max_length_r;
  afr_pkg::cfg_t        cfg;
  afr_pkg::result_t     res;
  afr_pkg::result_t     head;
  afr_pkg::queue_stat_t q_stat;
  logic res_valid;
  logic in_acc;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_gap_r   <= afr_pkg::IDLE_GAP_RST;
      max_length_r <= afr_pkg::MAX_LENGTH_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        afr_pkg::CFG_IDX_IDLE_GAP:   idle_gap_r   <= cfg_chan.data;
        afr_pkg::CFG_IDX_MAX_LENGTH: max_length_r <= cfg_chan.data[7:0];
      endcase
    end
  end

  assign cfg.idle_gap   = idle_gap_r;
  assign cfg.max_length = max_length_r;

  // input handshake
  assign in_chan.ready = ~q_stat.full;
  assign in_acc        = in_chan.valid & ~q_stat.full;

  afr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .mode      (in_chan.mode),
    .byte_in   (in_chan.byte_in),
    .cfg       (cfg),
    .res       (res),
    .res_valid (res_valid)
  );

  afr_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop_ready (out_chan.ready),
    .head      (head),
    .stat      (q_stat)
  );

  // result channel
  assign out_chan.valid        = q_stat.head_valid;
  assign out_chan.event_res    = head.event_res;
  assign out_chan.frame_type   = head.frame_type;
  assign out_chan.data_byte    = head.data_byte;
  assign out_chan.byte_index   = head.byte_index;
  assign out_chan.frame_length = head.frame_length;

  // skid entry is only used behind a held head entry
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> q_stat.head_valid)
    else $error("skid entry valid with empty head");

  // a tick can only end a frame as cut short
  a_tick_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.mode == afr_pkg::MODE_TICK && res_valid) |->
      res.event_res == afr_pkg::EV_CUT)
    else $error("tick produced an event other than cut short");

  // a payload transaction carries the byte just received
  a_payload_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.event_res == afr_pkg::EV_DATA) |->
      (in_acc && res.data_byte == in_chan.byte_in))
    else $error("payload result does not match the received byte");

endmodule

`default_nettype wire
